>>> sv/efc_pkg.sv
// Shared types, constants and helper functions for the elevator floor controller.
// Used by efc_step, the top level and the port checker; depends on nothing else.
package efc_pkg;

  // Number of floors served by the car.
  localparam int unsigned FLOOR_COUNT = 10;

  // Fixed widths of the stream fields.
  localparam int unsigned FloorW  = 4;
  localparam int unsigned MaskW   = 10;
  localparam int unsigned MotionW = 2;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 32;

  localparam logic [FloorW-1:0] TopFloor    = FloorW'(FLOOR_COUNT - 1);
  localparam logic [FloorW-1:0] GroundFloor = '0;
  localparam logic [MaskW-1:0]  AllFloors   =
      (FLOOR_COUNT >= MaskW) ? '1 : MaskW'((32'd1 << FLOOR_COUNT) - 32'd1);

  // Motion codes as they appear on the output word.
  localparam logic [MotionW-1:0] MotionStand = 2'd0;
  localparam logic [MotionW-1:0] MotionUp    = 2'd1;
  localparam logic [MotionW-1:0] MotionDown  = 2'd2;

  // Car mode, one-hot.
  typedef enum logic [2:0] {
    MODE_STAND = 3'b001,
    MODE_UP    = 3'b010,
    MODE_DOWN  = 3'b100
  } mode_e;

  // Stored controller state.
  typedef struct packed {
    logic [FloorW-1:0] floor;
    mode_e             mode;
    logic [MaskW-1:0]  hall;
    logic [MaskW-1:0]  car;
  } car_state_t;

  // Result of one step: the new state plus the event flags.
  typedef struct packed {
    car_state_t state;
    logic       alighted;
    logic       boarded;
  } step_t;

  // Converts the one-hot mode to the output motion code.
  function automatic logic [MotionW-1:0] mode_to_motion(mode_e mode);
    logic [MotionW-1:0] code;
    unique case (mode)
      MODE_UP:   code = MotionUp;
      MODE_DOWN: code = MotionDown;
      default:   code = MotionStand;
    endcase
    return code;
  endfunction

endpackage

>>> sv/efc_step.sv
// Combinational next-state logic for one controller tick.
// Depends on efc_pkg for the state types and floor constants.
module efc_step
  import efc_pkg::*;
(
  input  car_state_t        state_i,
  input  logic [MaskW-1:0]  hall_press_i,
  input  logic [MaskW-1:0]  car_press_i,
  input  logic [FloorW-1:0] boarding_destination_i,
  output step_t             step_o
);

  logic [MaskW-1:0]  hall_merged;
  logic [MaskW-1:0]  car_merged;
  logic [MaskW-1:0]  here;
  logic [MaskW-1:0]  above;
  logic [MaskW-1:0]  below;
  logic [MaskW-1:0]  dest_bit;
  logic [MaskW-1:0]  hall_nxt;
  logic [MaskW-1:0]  car_nxt;
  logic [FloorW-1:0] floor_up;
  logic [FloorW-1:0] floor_dn;
  logic              board_here;
  logic              alight_here;
  logic              alight_after_board;
  logic              move_up;
  logic              move_dn;
  logic              alighted;
  logic              boarded;

  // New presses join the stored calls; floors beyond the top are dropped.
  assign hall_merged = (state_i.hall | hall_press_i) & AllFloors;
  assign car_merged  = (state_i.car | car_press_i) & AllFloors;

  // Floor masks relative to the current floor.
  always_comb begin
    for (int i = 0; i < MaskW; i++) begin
      here[i]  = (FloorW'(i) == state_i.floor);
      above[i] = (FloorW'(i) > state_i.floor) && AllFloors[i];
      below[i] = (FloorW'(i) < state_i.floor);
    end
  end

  // A destination outside the building sets no car call.
  assign dest_bit = (32'(boarding_destination_i) < FLOOR_COUNT) ?
                    (MaskW'(1) << boarding_destination_i) : '0;

  assign board_here  = |(hall_merged & here);
  assign alight_here = |(car_merged & here);
  // Going down, boarding comes first, so a destination equal to this floor
  // is cleared again right away.
  assign alight_after_board = |((car_merged | (board_here ? dest_bit : '0)) & here);

  assign floor_up = state_i.floor + FloorW'(1);
  assign floor_dn = state_i.floor - FloorW'(1);

  // Mode-dependent serving of calls and choice of direction.
  always_comb begin
    hall_nxt = hall_merged;
    car_nxt  = car_merged;
    move_up  = 1'b0;
    move_dn  = 1'b0;
    alighted = 1'b0;
    boarded  = 1'b0;
    unique case (state_i.mode)
      MODE_UP: begin
        alighted = alight_here;
        car_nxt  = car_merged & ~here;
        move_up  = |((car_nxt | hall_nxt) & above);
      end
      MODE_DOWN: begin
        boarded  = board_here;
        hall_nxt = hall_merged & ~here;
        alighted = alight_after_board;
        car_nxt  = (car_merged | (board_here ? dest_bit : '0)) & ~here;
        move_dn  = |((car_nxt | hall_nxt) & below);
      end
      default: begin
        alighted = alight_here;
        boarded  = board_here;
        hall_nxt = hall_merged & ~here;
        car_nxt  = (car_merged & ~here) | (board_here ? dest_bit : '0);
        priority if (|(car_nxt & above)) begin
          move_up = 1'b1;
        end else if (|(car_nxt & below)) begin
          move_dn = 1'b1;
        end else if (|(hall_nxt & above)) begin
          move_up = 1'b1;
        end else if (|(hall_nxt & below)) begin
          move_dn = 1'b1;
        end else begin
          // No call anywhere: the car stays where it is.
          move_up = 1'b0;
        end
      end
    endcase
  end

  // One floor per tick; reaching either end of the shaft stops the car.
  always_comb begin
    step_o.alighted   = alighted;
    step_o.boarded    = boarded;
    step_o.state.hall = hall_nxt;
    step_o.state.car  = car_nxt;
    priority if (move_up) begin
      step_o.state.floor = floor_up;
      step_o.state.mode  = (floor_up == TopFloor) ? MODE_STAND : MODE_UP;
    end else if (move_dn) begin
      step_o.state.floor = floor_dn;
      step_o.state.mode  = (floor_dn == GroundFloor) ? MODE_STAND : MODE_DOWN;
    end else begin
      step_o.state.floor = state_i.floor;
      step_o.state.mode  = MODE_STAND;
    end
  end

endmodule

>>> sv/elevator_floor_controller_top.sv
// Elevator floor controller: one input word per tick, one result word per tick.
// Car state registers, efc_step for the transition and an output register.
// Depends on efc_pkg and efc_step.
//
// Each accepted input word is one controller tick and yields exactly one
// result word in the next cycle. A word can be accepted every cycle; the only
// thing that holds the input back is the single output register, which is
// refilled in the same cycle it is drained, so throughput is one word per
// clock as long as the sink keeps tready high. After reset the car stands at
// the ground floor with no calls stored.
module elevator_floor_controller_top
  import efc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [9:0] hall_press, [19:10] car_press, [23:20] boarding_destination
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [3:0] floor_now, [5:4] motion, [15:6] hall_pending, [25:16] car_pending,
  // [26] alighted, [27] boarded, [31:28] zero
  output logic [OutDataW-1:0] m_axis_tdata
);

  car_state_t          state_q;
  step_t               step;
  logic                in_accept;
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic [OutDataW-1:0] out_data_d;

  // Transition logic for one tick.
  efc_step u_step (
    .state_i                (state_q),
    .hall_press_i           (s_axis_tdata[9:0]),
    .car_press_i            (s_axis_tdata[19:10]),
    .boarding_destination_i (s_axis_tdata[23:20]),
    .step_o                 (step)
  );

  // The output register frees up in the same cycle it is drained.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Car state advances once per accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.floor <= GroundFloor;
      state_q.mode  <= MODE_STAND;
      state_q.hall  <= '0;
      state_q.car   <= '0;
    end else if (in_accept) begin
      state_q <= step.state;
    end
  end

  // Result word packing.
  assign out_data_d = {4'b0000, step.boarded, step.alighted, step.state.car,
                       step.state.hall, mode_to_motion(step.state.mode),
                       step.state.floor};

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> sv/efc_checker.sv
// Port-level checks for the elevator floor controller, bound to the top level.
// Depends on efc_pkg and elevator_floor_controller_top.
module efc_checker
  import efc_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [InDataW-1:0]  s_axis_tdata,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // A stalled result word holds still.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // Every accepted tick shows up as a result word in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted word produced no result");

  // The car never leaves the shaft.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[3:0] <= TopFloor)
    else $error("floor out of range");

  // A car moving up is never at either end of the shaft.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[5:4] == MotionUp
      |-> m_axis_tdata[3:0] != GroundFloor && m_axis_tdata[3:0] != TopFloor)
    else $error("car moving up at an end floor");

  // A car moving down has not reached the ground floor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[5:4] == MotionDown
      |-> m_axis_tdata[3:0] != GroundFloor)
    else $error("car moving down at the ground floor");

endmodule

bind elevator_floor_controller_top efc_checker u_efc_checker (.*);
